// ===== sv/rwev_pkg.sv =====
// ----------------------------------------------------------------------------
// rwev_pkg - shared types and constants
// Widths, coefficients and the sideband record carried down the pipeline.
// ----------------------------------------------------------------------------
package rwev_pkg;

	localparam int FLD_W    = 48;
	localparam int CFG_W    = 32;
	localparam int CFG_AW   = 2;
	localparam int OUT_W    = 64;
	localparam int IN_DW    = 4 * FLD_W;
	localparam int OUT_DW   = 2 * OUT_W;

	localparam int RAD_W    = 80;
	localparam int ROOT_W   = 40;

	localparam int DIV_NW   = 128;
	localparam int DIV_DW   = 64;
	localparam int DIV_QW   = DIV_NW - DIV_DW;

	localparam int MUL_W    = 64;
	localparam int MUL_H    = 32;

	localparam int LOG_FRAC = 56;
	localparam int EXP_W    = 6;
	localparam int LA_W     = FLD_W + 1;

	localparam logic [CFG_AW-1:0] REG_CMU   = 2'd0;
	localparam logic [CFG_AW-1:0] REG_KAPPA = 2'd1;

	localparam logic [CFG_W-1:0] CMU_RST   = 32'd386547057;
	localparam logic [CFG_W-1:0] KAPPA_RST = 32'd1760936591;

	localparam logic [MUL_W-1:0] LN2_Q64  = 64'hB17217F7D1CF79AB;
	localparam logic [OUT_W-1:0] ONE_Q32  = 64'h0000_0001_0000_0000;
	localparam logic [OUT_W-1:0] NUT_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [FLD_W-1:0]    k;
		logic [FLD_W-1:0]    y;
		logic [FLD_W-1:0]    nu;
		logic [FLD_W-1:0]    z0;
		logic [OUT_W-1:0]    yplus;
		logic [MUL_W-1:0]    lnv;
		logic [LOG_FRAC-1:0] frac;
		logic [EXP_W-1:0]    e;
		logic                wnz;
		logic                lzero;
		logic                ge;
	} side_t;

	// position of the highest set bit, zero for a zero word
	function automatic logic [EXP_W-1:0] msb_pos(input logic [LA_W-1:0] x);
		logic [EXP_W-1:0] r;
		r = '0;
		for (int i = 0; i < LA_W; i++) begin
			if (x[i]) r = EXP_W'(i);
		end
		return r;
	endfunction

endpackage

// ===== sv/rough_wall_eddy_viscosity.sv =====
// ----------------------------------------------------------------------------
// rough_wall_eddy_viscosity - rough-wall eddy viscosity for boundary faces
//
// One boundary face per word on the s_axis channel: k, wall distance y,
// laminar viscosity nu and roughness length z0, unsigned Q16.32 each.
// One result word per face on m_axis: nut (signed Q31.32) and yPlus
// (unsigned Q32.32), both saturated; tuser flags zero nu or zero z0.
// The cfg channel writes Cmu (index 0) and kappa (index 1), Q0.32; it is
// always ready and is meant to be written only while no face is in flight.
//
// Throughput is one face per cycle while the output is not stalled. The
// bit-serial stages are two 40-stage square roots, three 65-stage dividers
// and 56 two-stage squarings in the log unit.
// Reset clears every valid bit and loads the default coefficients.
// A stalled output holds its word and freezes the whole pipeline; tready on
// the input follows that freeze, so no face is dropped or repeated.
// ----------------------------------------------------------------------------
module rough_wall_eddy_viscosity (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [47:0] turb_energy, [95:48] wall_dist, [143:96] lam_visc,
	// [191:144] rough_len
	input  logic [rwev_pkg::IN_DW-1:0]     s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [63:0] eddy_visc, [127:64] yplus_val
	output logic [rwev_pkg::OUT_DW-1:0]    m_axis_tdata,
	// [0] bad_operand
	output logic [0:0]                     m_axis_tuser,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rwev_pkg::CFG_AW-1:0]    cfg_addr,
	input  logic [rwev_pkg::CFG_W-1:0]     cfg_data
);
	localparam int FW = rwev_pkg::FLD_W;
	localparam int MW = rwev_pkg::MUL_W;
	localparam int OW = rwev_pkg::OUT_W;

	logic                    en;
	logic [rwev_pkg::CFG_W-1:0] cmu_q, kappa_q;

	// the whole pipe advances unless a finished word is stuck at the output
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmu_q   <= rwev_pkg::CMU_RST;
			kappa_q <= rwev_pkg::KAPPA_RST;
		end else if (cfg_valid) begin
			case (cfg_addr)
				rwev_pkg::REG_CMU:   cmu_q   <= cfg_data;
				rwev_pkg::REG_KAPPA: kappa_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// unpack the face
	rwev_pkg::side_t side0;
	always_comb begin
		side0    = '0;
		side0.k  = s_axis_tdata[FW-1:0];
		side0.y  = s_axis_tdata[2*FW-1:FW];
		side0.nu = s_axis_tdata[3*FW-1:2*FW];
		side0.z0 = s_axis_tdata[4*FW-1:3*FW];
	end

	// c2 = sqrt(Cmu), Q0.32
	logic                          v1;
	logic [rwev_pkg::ROOT_W-1:0]   root1;
	rwev_pkg::side_t               side1;

	rwev_sqrt u_sqrt_cmu (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid (s_axis_tvalid),
		.rad      ({16'b0, cmu_q, 32'b0}),
		.in_side  (side0),
		.out_valid(v1), .root(root1), .out_side(side1)
	);

	// c2 * k
	logic            v2;
	logic [2*MW-1:0] p2;
	rwev_pkg::side_t side2;

	rwev_mul u_mul_k (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid (v1),
		.a        ({32'b0, root1[31:0]}),
		.b        ({16'b0, side1.k}),
		.in_side  (side1),
		.out_valid(v2), .prod(p2), .out_side(side2)
	);

	// friction velocity, Q8.32
	logic                          v3;
	logic [rwev_pkg::ROOT_W-1:0]   ustar;
	rwev_pkg::side_t               side3;

	rwev_sqrt u_sqrt_ustar (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid (v2),
		.rad      (p2[rwev_pkg::RAD_W-1:0]),
		.in_side  (side2),
		.out_valid(v3), .root(ustar), .out_side(side3)
	);

	// uStar * y
	logic            v4;
	logic [2*MW-1:0] p4;
	rwev_pkg::side_t side4;

	rwev_mul u_mul_y (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid (v3),
		.a        ({24'b0, ustar}),
		.b        ({16'b0, side3.y}),
		.in_side  (side3),
		.out_valid(v4), .prod(p4), .out_side(side4)
	);

	// yPlus = uStar*y/nu, saturating
	logic            v5, ovf5;
	logic [MW-1:0]   q5;
	rwev_pkg::side_t side5r, side5;

	rwev_div u_div_yplus (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid (v4),
		.num      (p4),
		.den      ({16'b0, side4.nu}),
		.in_side  (side4),
		.out_valid(v5), .quo(q5), .ovf(ovf5), .out_side(side5r)
	);

	always_comb begin
		side5       = side5r;
		side5.yplus = ovf5 ? '1 : q5;
	end

	// ln((y+z0)/z0), Q7.56
	logic            v6;
	logic [MW-1:0]   lnv6;
	rwev_pkg::side_t side6r, side6;

	rwev_log u_log (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid (v5),
		.num_a    ({1'b0, side5.y} + {1'b0, side5.z0}),
		.den_b    (side5.z0),
		.in_side  (side5),
		.out_valid(v6), .lnv(lnv6), .out_side(side6r)
	);

	always_comb begin
		side6     = side6r;
		side6.lnv = lnv6;
	end

	// yPlus * kappa
	logic            v7;
	logic [2*MW-1:0] p7;
	rwev_pkg::side_t side7r, side7;

	rwev_mul u_mul_kappa (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid (v6),
		.a        (side6.yplus),
		.b        ({32'b0, kappa_q}),
		.in_side  (side6),
		.out_valid(v7), .prod(p7), .out_side(side7r)
	);

	always_comb begin
		side7       = side7r;
		side7.wnz   = |p7;
		side7.lzero = side7r.lnv == '0;
	end

	// T = yPlus*kappa/ln, Q32.32
	logic            v8, ovf8;
	logic [MW-1:0]   q8;
	rwev_pkg::side_t side8;

	rwev_div u_div_t (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid (v7),
		.num      ({p7[103:0], 24'b0}),
		.den      (side7.lnv),
		.in_side  (side7),
		.out_valid(v8), .quo(q8), .ovf(ovf8), .out_side(side8)
	);

	// pick T, then form |T - 1| and its sign
	logic [OW-1:0]   t8;
	logic            ge8;
	rwev_pkg::side_t side8g;
	always_comb begin
		if (side8.lzero) t8 = side8.wnz ? '1 : '0;
		else             t8 = ovf8 ? '1 : q8;
		ge8       = |t8[OW-1:32];
		side8g    = side8;
		side8g.ge = ge8;
	end

	logic            sub_valid_s1;
	logic [OW-1:0]   sub_dt_s1;
	rwev_pkg::side_t sub_side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sub_valid_s1 <= 1'b0;
		else if (en) sub_valid_s1 <= v8;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sub_dt_s1   <= ge8 ? (t8 - rwev_pkg::ONE_Q32) : (rwev_pkg::ONE_Q32 - t8);
			sub_side_s1 <= side8g;
		end
	end

	// nu * |T - 1|
	logic            v9;
	logic [2*MW-1:0] p9;
	rwev_pkg::side_t side9;

	rwev_mul u_mul_nu (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid (sub_valid_s1),
		.a        ({16'b0, sub_side_s1.nu}),
		.b        (sub_dt_s1),
		.in_side  (sub_side_s1),
		.out_valid(v9), .prod(p9), .out_side(side9)
	);

	// saturate, apply sign, override for bad operands
	logic [OW-1:0] nut9, yp9;
	logic          bad9;
	always_comb begin
		bad9 = (side9.nu == '0) || (side9.z0 == '0);
		yp9  = side9.yplus;
		if (side9.ge) begin
			if ((|p9[127:96]) || p9[95]) nut9 = rwev_pkg::NUT_MAX;
			else                         nut9 = p9[95:32];
		end else begin
			nut9 = '0 - p9[95:32];
		end
		if (bad9) begin
			nut9 = rwev_pkg::NUT_MAX;
			yp9  = '1;
		end
	end

	logic            out_valid_q;
	logic [OW-1:0]   nut_q, yplus_q;
	logic            bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= v9;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nut_q   <= nut9;
			yplus_q <= yp9;
			bad_q   <= bad9;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {yplus_q, nut_q};
	assign m_axis_tuser[0] = bad_q;

endmodule

// ===== sv/rwev_mul.sv =====
// ----------------------------------------------------------------------------
// rwev_mul - two-stage 64x64 multiplier
// Four 32x32 partial products, then one registered sum.
// ----------------------------------------------------------------------------
module rwev_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [rwev_pkg::MUL_W-1:0]    a,
	input  logic [rwev_pkg::MUL_W-1:0]    b,
	input  rwev_pkg::side_t               in_side,
	output logic                          out_valid,
	output logic [2*rwev_pkg::MUL_W-1:0]  prod,
	output rwev_pkg::side_t               out_side
);
	localparam int H = rwev_pkg::MUL_H;

	logic                 v_s1, v_s2;
	logic [2*H-1:0]       p00_s1, p01_s1, p10_s1, p11_s1;
	logic [4*H-1:0]       prod_s2;
	rwev_pkg::side_t      side_s1, side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1  <= a[H-1:0] * b[H-1:0];
			p01_s1  <= a[H-1:0] * b[2*H-1:H];
			p10_s1  <= a[2*H-1:H] * b[H-1:0];
			p11_s1  <= a[2*H-1:H] * b[2*H-1:H];
			side_s1 <= in_side;
			prod_s2 <= {p11_s1, {(2*H){1'b0}}} + {{H{1'b0}}, p01_s1, {H{1'b0}}}
				+ {{H{1'b0}}, p10_s1, {H{1'b0}}} + {{(2*H){1'b0}}, p00_s1};
			side_s2 <= side_s1;
		end
	end

	assign out_valid = v_s2;
	assign prod      = prod_s2;
	assign out_side  = side_s2;

endmodule

// ===== sv/rwev_sqrt.sv =====
// ----------------------------------------------------------------------------
// rwev_sqrt - pipelined integer square root
// One root bit per stage, restoring digit recurrence.
// ----------------------------------------------------------------------------
module rwev_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [rwev_pkg::RAD_W-1:0]    rad,
	input  rwev_pkg::side_t               in_side,
	output logic                          out_valid,
	output logic [rwev_pkg::ROOT_W-1:0]   root,
	output rwev_pkg::side_t               out_side
);
	localparam int RW  = rwev_pkg::ROOT_W;
	localparam int DW  = rwev_pkg::RAD_W;
	localparam int NST = RW;

	logic              v_s    [NST+1];
	logic [DW-1:0]     rad_s  [NST+1];
	logic [RW+1:0]     rem_s  [NST+1];
	logic [RW-1:0]     root_s [NST+1];
	rwev_pkg::side_t   side_s [NST+1];

	assign v_s[0]    = in_valid;
	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar i = 0; i < NST; i++) begin : g_st
		logic [RW+3:0] cur, trial, diff;
		always_comb begin
			cur   = {rem_s[i], rad_s[i][DW-1 -: 2]};
			trial = {2'b00, root_s[i], 2'b01};
			diff  = cur - trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i+1] <= 1'b0;
			else if (en) v_s[i+1] <= v_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i+1]  <= rad_s[i] << 2;
				side_s[i+1] <= side_s[i];
				if (cur >= trial) begin
					rem_s[i+1]  <= diff[RW+1:0];
					root_s[i+1] <= {root_s[i][RW-2:0], 1'b1};
				end else begin
					rem_s[i+1]  <= cur[RW+1:0];
					root_s[i+1] <= {root_s[i][RW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_s[NST];
	assign root      = root_s[NST];
	assign out_side  = side_s[NST];

endmodule

// ===== sv/rwev_div.sv =====
// ----------------------------------------------------------------------------
// rwev_div - pipelined 128/64 divider
// Overflow check stage, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module rwev_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [rwev_pkg::DIV_NW-1:0]   num,
	input  logic [rwev_pkg::DIV_DW-1:0]   den,
	input  rwev_pkg::side_t               in_side,
	output logic                          out_valid,
	output logic [rwev_pkg::DIV_QW-1:0]   quo,
	output logic                          ovf,
	output rwev_pkg::side_t               out_side
);
	localparam int NW  = rwev_pkg::DIV_NW;
	localparam int DW  = rwev_pkg::DIV_DW;
	localparam int QW  = rwev_pkg::DIV_QW;
	localparam int NST = QW;

	logic              v_s    [NST+1];
	logic [DW-1:0]     rem_s  [NST+1];
	logic [QW-1:0]     lo_s   [NST+1];
	logic [QW-1:0]     quo_s  [NST+1];
	logic [DW-1:0]     den_s  [NST+1];
	logic              ovf_s  [NST+1];
	rwev_pkg::side_t   side_s [NST+1];

	logic [DW-1:0] num_hi;
	logic          big;

	assign num_hi = num[NW-1 -: DW];
	assign big    = num_hi >= den;

	// quotient would not fit: flag it and run the rest on a zero remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (en) v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0]  <= big;
			rem_s[0]  <= big ? '0 : num_hi;
			lo_s[0]   <= num[QW-1:0];
			quo_s[0]  <= '0;
			den_s[0]  <= den;
			side_s[0] <= in_side;
		end
	end

	for (genvar i = 0; i < NST; i++) begin : g_st
		logic [DW:0] cur, dz, diff;
		always_comb begin
			cur  = {rem_s[i], lo_s[i][QW-1]};
			dz   = {1'b0, den_s[i]};
			diff = cur - dz;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i+1] <= 1'b0;
			else if (en) v_s[i+1] <= v_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lo_s[i+1]   <= lo_s[i] << 1;
				den_s[i+1]  <= den_s[i];
				ovf_s[i+1]  <= ovf_s[i];
				side_s[i+1] <= side_s[i];
				if (cur >= dz) begin
					rem_s[i+1] <= diff[DW-1:0];
					quo_s[i+1] <= {quo_s[i][QW-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= cur[DW-1:0];
					quo_s[i+1] <= {quo_s[i][QW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_s[NST];
	assign quo       = quo_s[NST];
	assign ovf       = ovf_s[NST];
	assign out_side  = side_s[NST];

endmodule

// ===== sv/rwev_log.sv =====
// ----------------------------------------------------------------------------
// rwev_log - pipelined natural log of a ratio
// Integer part by leading-one search, mantissa by division, fraction bits by
// repeated squaring, then scaling by ln(2).
// ----------------------------------------------------------------------------
module rwev_log (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [rwev_pkg::LA_W-1:0]     num_a,
	input  logic [rwev_pkg::FLD_W-1:0]    den_b,
	input  rwev_pkg::side_t               in_side,
	output logic                          out_valid,
	output logic [rwev_pkg::MUL_W-1:0]    lnv,
	output rwev_pkg::side_t               out_side
);
	localparam int AW = rwev_pkg::LA_W;
	localparam int EW = rwev_pkg::EXP_W;
	localparam int NF = rwev_pkg::LOG_FRAC;
	localparam int MW = rwev_pkg::MUL_W;

	logic              v_s1, v_s2;
	logic [AW-1:0]     a_s1, b_s1, a_s2, den_s2;
	logic [EW-1:0]     ma_s1, mb_s1;
	rwev_pkg::side_t   side_s1, side_s2;

	logic [EW-1:0]     d;
	logic [AW-1:0]     bs;
	logic              fits;
	rwev_pkg::side_t   side_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_comb begin
		d    = ma_s1 - mb_s1;
		bs   = b_s1 << d;
		fits = bs <= a_s1;
		// step back one octave when the aligned divisor overshoots
		side_n   = side_s1;
		side_n.e = fits ? d : (d - EW'(1));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= num_a;
			b_s1    <= {1'b0, den_b};
			ma_s1   <= rwev_pkg::msb_pos(num_a);
			mb_s1   <= rwev_pkg::msb_pos({1'b0, den_b});
			side_s1 <= in_side;
			a_s2    <= a_s1;
			den_s2  <= fits ? bs : (bs >> 1);
			side_s2 <= side_n;
		end
	end

	// mantissa in Q1.62
	logic              dv_v;
	logic [MW-1:0]     dv_q;
	logic              dv_ovf;
	rwev_pkg::side_t   dv_side;

	rwev_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.num      ({17'b0, a_s2, 62'b0}),
		.den      ({15'b0, den_s2}),
		.in_side  (side_s2),
		.out_valid(dv_v),
		.quo      (dv_q),
		.ovf      (dv_ovf),
		.out_side (dv_side)
	);

	logic              sq_v    [NF+1];
	logic [MW-1:0]     sq_m    [NF+1];
	rwev_pkg::side_t   sq_side [NF+1];

	assign sq_v[0]    = dv_v;
	assign sq_m[0]    = dv_ovf ? '0 : dv_q;
	assign sq_side[0] = dv_side;

	for (genvar j = 0; j < NF; j++) begin : g_sq
		logic [2*MW-1:0]   p;
		logic              pv;
		rwev_pkg::side_t   ps;
		logic [MW-1:0]     s;

		rwev_mul u_mul (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (sq_v[j]),
			.a        (sq_m[j]),
			.b        (sq_m[j]),
			.in_side  (sq_side[j]),
			.out_valid(pv),
			.prod     (p),
			.out_side (ps)
		);

		// square >= 2 sets the bit and halves the mantissa
		always_comb begin
			s          = p[125:62];
			sq_v[j+1]  = pv;
			sq_m[j+1]  = s[MW-1] ? {1'b0, s[MW-1:1]} : s;
			sq_side[j+1]      = ps;
			sq_side[j+1].frac = {ps.frac[NF-2:0], s[MW-1]};
		end
	end

	logic [2*MW-1:0] ln_p;

	rwev_mul u_ln (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_v[NF]),
		.a        ({2'b0, sq_side[NF].e, sq_side[NF].frac}),
		.b        (rwev_pkg::LN2_Q64),
		.in_side  (sq_side[NF]),
		.out_valid(out_valid),
		.prod     (ln_p),
		.out_side (out_side)
	);

	assign lnv = ln_p[2*MW-1:MW];

endmodule

// ===== sv/rwev_chk.sv =====
// ----------------------------------------------------------------------------
// rwev_chk - port checker for rough_wall_eddy_viscosity
// Watches the stream ports for stall behavior and flagged results.
// ----------------------------------------------------------------------------
module rwev_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [rwev_pkg::IN_DW-1:0]     s_axis_tdata,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [rwev_pkg::OUT_DW-1:0]    m_axis_tdata,
	input logic [0:0]                     m_axis_tuser,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [rwev_pkg::CFG_AW-1:0]    cfg_addr,
	input logic [rwev_pkg::CFG_W-1:0]     cfg_data
);

	// hold a stalled output word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled output word changed");

	// a stalled output freezes the input side
	a_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted while output stalled");

	// flagged faces carry saturated results
	a_bad_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
			m_axis_tdata[63:0] == rwev_pkg::NUT_MAX && m_axis_tdata[127:64] == '1)
		else $error("flagged word not saturated");

endmodule

bind rough_wall_eddy_viscosity rwev_chk u_rwev_chk (.*);

// ===== verif/tb_rough_wall_eddy_viscosity.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rough_wall_eddy_viscosity - self-checking bench for the wall function
// Streams boundary faces through the block under several coefficient
// settings. Each accepted face is predicted by the bench's own fixed-point
// wall-function model or typed in its directed row; output words are checked
// in order against those. Sender bursts and receiver stalls are randomized.
// ----------------------------------------------------------------------------
module tb_rough_wall_eddy_viscosity;

	// indexes past the last register: writes there must change nothing
	localparam logic [rwev_pkg::CFG_AW-1:0] REG_SPARE2 = 2'd2;
	localparam logic [rwev_pkg::CFG_AW-1:0] REG_SPARE3 = 2'd3;
	localparam logic [rwev_pkg::FLD_W-1:0]  FLD_MAX    = {rwev_pkg::FLD_W{1'b1}};
	localparam logic [rwev_pkg::OUT_W-1:0]  YP_MAX     = {rwev_pkg::OUT_W{1'b1}};
	localparam int                          DRAIN_CYC  = 420;
	localparam int                          RAND_ITEMS = 262;

	typedef struct {
		logic [rwev_pkg::FLD_W-1:0] k, y, nu, z0;
	} face_t;

	typedef struct {
		logic [rwev_pkg::OUT_W-1:0] nut;
		logic [rwev_pkg::OUT_W-1:0] yplus;
		logic                       bad;
	} wall_res_t;

	// directed row: typed expectation only where it is obvious
	typedef struct {
		face_t     f;
		bit        typed;
		wall_res_t res;
	} face_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          s_axis_tvalid;
	logic                          s_axis_tready;
	logic [rwev_pkg::IN_DW-1:0]    s_axis_tdata;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready;
	logic [rwev_pkg::OUT_DW-1:0]   m_axis_tdata;
	logic [0:0]                    m_axis_tuser;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [rwev_pkg::CFG_AW-1:0]   cfg_addr;
	logic [rwev_pkg::CFG_W-1:0]    cfg_data;

	// bench copy of the coefficient registers
	logic [rwev_pkg::CFG_W-1:0] cmu_q;
	logic [rwev_pkg::CFG_W-1:0] kappa_q;

	wall_res_t pending_res[$];
	int        mismatches;
	int        burst_left;

	rough_wall_eddy_viscosity dut (.*);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// ------------------------------------------------------------------
	// fixed-point wall function
	// ------------------------------------------------------------------
	function automatic logic [63:0] isqrt(input logic [127:0] x);
		logic [63:0]  r;
		logic [63:0]  t;
		logic [127:0] tt;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			t  = r | (64'd1 << b);
			tt = {64'd0, t} * {64'd0, t};
			if (tt <= x) r = t;
		end
		return r;
	endfunction

	// log2(a/b) in Q7.56
	function automatic logic [63:0] log2_q56(input logic [63:0] a, input logic [63:0] b);
		int           e;
		logic [127:0] m;
		logic [127:0] sq;
		logic [63:0]  s;
		logic [63:0]  frac;
		e = 0;
		frac = '0;
		while (e < 60 && ({64'd0, b} << (e + 1)) <= {64'd0, a}) e++;
		m = (({64'd0, a} << 62) / ({64'd0, b} << e)) & {64'd0, {64{1'b1}}};
		for (int i = 0; i < rwev_pkg::LOG_FRAC; i++) begin
			sq   = m * m;
			s    = sq[125:62];
			frac = frac << 1;
			if (s[63]) begin
				frac[0] = 1'b1;
				m = {64'd0, s >> 1};
			end else begin
				m = {64'd0, s};
			end
		end
		return (64'(e) << rwev_pkg::LOG_FRAC) | frac;
	endfunction

	function automatic wall_res_t wall_visc(input face_t f);
		wall_res_t    r;
		logic [63:0]  c2, ustar, lnv, t;
		logic [127:0] q, w;
		if (f.nu == 0 || f.z0 == 0) begin
			r.nut = rwev_pkg::NUT_MAX; r.yplus = YP_MAX; r.bad = 1'b1;
			return r;
		end
		r.bad = 1'b0;
		c2    = isqrt({64'd0, cmu_q, 32'd0});
		ustar = isqrt(128'(c2) * 128'(f.k));
		q     = (128'(ustar) * 128'(f.y)) / 128'(f.nu);
		r.yplus = (q[127:64] != 0) ? YP_MAX : q[63:0];
		w   = 128'(log2_q56(64'(f.y) + 64'(f.z0), 64'(f.z0))) * 128'(rwev_pkg::LN2_Q64);
		lnv = w[127:64];
		w   = 128'(r.yplus) * 128'(kappa_q);
		if (lnv == 0) begin
			t = (w != 0) ? YP_MAX : '0;
		end else begin
			q = (w << 24) / 128'(lnv);
			t = (q[127:64] != 0) ? YP_MAX : q[63:0];
		end
		if (t >= rwev_pkg::ONE_Q32) begin
			w = 128'(f.nu) * 128'(t - rwev_pkg::ONE_Q32);
			if (w[127:96] != 0 || w[95]) r.nut = rwev_pkg::NUT_MAX;
			else r.nut = w[95:32];
		end else begin
			w = 128'(f.nu) * 128'(rwev_pkg::ONE_Q32 - t);
			r.nut = -w[95:32];
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// handshake helpers; everything is driven on the falling edge
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [rwev_pkg::CFG_AW-1:0] idx,
			input logic [rwev_pkg::CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_addr  <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			rwev_pkg::REG_CMU:   cmu_q   = val;
			rwev_pkg::REG_KAPPA: kappa_q = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// send one face; the expected word is queued at the accepting edge
	task automatic send_face(input face_t f, input bit typed, input wall_res_t res);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {f.z0, f.nu, f.y, f.k};
		do @(posedge clk); while (!s_axis_tready);
		pending_res.push_back(typed ? res : wall_visc(f));
		@(negedge clk);
	endtask

	// hold off until the pipe is empty; the block is then idle
	task automatic drain_faces();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_res.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic logic [rwev_pkg::FLD_W-1:0] rand_fld();
		logic [rwev_pkg::FLD_W-1:0] v;
		v = rwev_pkg::FLD_W'({$urandom, $urandom});
		case ($urandom_range(0, 9))
			0:       return FLD_MAX;
			1:       return v;
			default: return v >> $urandom_range(0, 47);
		endcase
	endfunction

	// mostly plausible faces, some degenerate ones
	function automatic face_t rand_face();
		face_t f;
		f.k  = rand_fld();
		f.y  = rand_fld();
		f.nu = rand_fld();
		f.z0 = rand_fld();
		case ($urandom_range(0, 19))
			0:       f.nu = '0;
			1:       f.z0 = '0;
			2:       f.y  = '0;
			3:       f.k  = '0;
			default: ;
		endcase
		if (f.nu == 0 && $urandom_range(0, 1) == 0) f.nu = 48'd1;
		return f;
	endfunction

	// ------------------------------------------------------------------
	// receiver: a randomly redrawn stall mode shapes tready across cycles
	// ------------------------------------------------------------------
	int stall_mode;
	int stall_cnt;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_mode <= 0;
			stall_cnt  <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0:       m_axis_tready <= 1'b1;
				1:       m_axis_tready <= ($urandom_range(0, 9) < 7);
				2:       m_axis_tready <= (stall_cnt % 5 != 0);
				default: m_axis_tready <= (stall_cnt % 16 < 4);
			endcase
		end
	end

	// check every output word against the oldest expectation
	always @(posedge clk) begin
		wall_res_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_res.size() == 0) begin
				$display("%0t: unexpected word %h / %b", $realtime, m_axis_tdata,
					m_axis_tuser);
				mismatches++;
			end else begin
				exp_r = pending_res.pop_front();
				if (m_axis_tdata[63:0] !== exp_r.nut) begin
					$display("%0t: eddy_visc expected %h actual %h", $realtime,
						exp_r.nut, m_axis_tdata[63:0]);
					mismatches++;
				end
				if (m_axis_tdata[127:64] !== exp_r.yplus) begin
					$display("%0t: yplus_val expected %h actual %h", $realtime,
						exp_r.yplus, m_axis_tdata[127:64]);
					mismatches++;
				end
				if (m_axis_tuser[0] !== exp_r.bad) begin
					$display("%0t: bad_operand expected %b actual %b", $realtime,
						exp_r.bad, m_axis_tuser[0]);
					mismatches++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	face_row_t dir_rows[$];

	function automatic face_row_t mk_row(input logic [rwev_pkg::FLD_W-1:0] k, y, nu, z0,
			input bit typed, input logic [rwev_pkg::OUT_W-1:0] nut, yp, input logic bad);
		face_row_t r;
		r.f.k = k; r.f.y = y; r.f.nu = nu; r.f.z0 = z0;
		r.typed = typed;
		r.res.nut = nut; r.res.yplus = yp; r.res.bad = bad;
		return r;
	endfunction

	initial begin
		face_t     f;
		wall_res_t none;
		none = '{default: '0};
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_addr      = '0;
		cfg_data      = '0;
		mismatches    = 0;
		burst_left    = 0;
		cmu_q   = rwev_pkg::CMU_RST;
		kappa_q = rwev_pkg::KAPPA_RST;
		arst_n  = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// zero viscosity or roughness: saturated, flagged
		dir_rows.push_back(mk_row('0, '0, '0, '0, 1'b1, rwev_pkg::NUT_MAX, YP_MAX, 1'b1));
		dir_rows.push_back(mk_row(FLD_MAX, FLD_MAX, '0, FLD_MAX, 1'b1,
			rwev_pkg::NUT_MAX, YP_MAX, 1'b1));
		dir_rows.push_back(mk_row(FLD_MAX, FLD_MAX, FLD_MAX, '0, 1'b1,
			rwev_pkg::NUT_MAX, YP_MAX, 1'b1));
		// face on the wall: nut is minus nu
		dir_rows.push_back(mk_row(FLD_MAX, '0, FLD_MAX, 48'd1, 1'b1,
			-{16'd0, FLD_MAX}, '0, 1'b0));
		dir_rows.push_back(mk_row('0, '0, 48'd1, FLD_MAX, 1'b1, -64'd1, '0, 1'b0));
		// extremes and typical faces, predicted
		dir_rows.push_back(mk_row(FLD_MAX, FLD_MAX, FLD_MAX, FLD_MAX, 1'b0, '0, '0, 1'b0));
		dir_rows.push_back(mk_row(48'd1, 48'd1, 48'd1, 48'd1, 1'b0, '0, '0, 1'b0));
		dir_rows.push_back(mk_row('0, 48'h1_0000_0000, 48'd64424, 48'd429497, 1'b0,
			'0, '0, 1'b0));
		dir_rows.push_back(mk_row(48'h1_0000_0000, 48'h1_0000_0000, 48'd64424,
			48'd429497, 1'b0, '0, '0, 1'b0));
		dir_rows.push_back(mk_row(FLD_MAX, FLD_MAX, 48'd1, 48'd1, 1'b0, '0, '0, 1'b0));
		dir_rows.push_back(mk_row(FLD_MAX, FLD_MAX, 48'd1, FLD_MAX, 1'b0, '0, '0, 1'b0));
		dir_rows.push_back(mk_row(48'h5_0000_0000, 48'h3_0000_0000, 48'd1 << 32,
			48'd1 << 28, 1'b0, '0, '0, 1'b0));
		foreach (dir_rows[i]) send_face(dir_rows[i].f, dir_rows[i].typed, dir_rows[i].res);
		drain_faces();

		// walk the coefficient settings: defaults, extremes, defaults with spare writes, then random ones
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: ;
				1: begin
					write_reg(rwev_pkg::REG_CMU, '0); write_reg(rwev_pkg::REG_KAPPA, '1);
				end
				2: begin
					write_reg(rwev_pkg::REG_CMU, '1); write_reg(rwev_pkg::REG_KAPPA, '0);
				end
				3: begin
					write_reg(rwev_pkg::REG_CMU, '1); write_reg(rwev_pkg::REG_KAPPA, '1);
				end
				4: begin
					write_reg(rwev_pkg::REG_CMU, rwev_pkg::CMU_RST);
					write_reg(rwev_pkg::REG_KAPPA, rwev_pkg::KAPPA_RST);
					write_reg(REG_SPARE2, $urandom); write_reg(REG_SPARE3, $urandom);
				end
				default: begin
					write_reg(rwev_pkg::REG_CMU, $urandom);
					write_reg(rwev_pkg::REG_KAPPA, $urandom);
				end
			endcase
			for (int n = 0; n < RAND_ITEMS; n++) begin
				f = rand_face();
				send_face(f, 1'b0, none);
				// pressure: let the pipe run dry mid-phase once
				if (ph == 5 && n == RAND_ITEMS / 2) drain_faces();
			end
			drain_faces();
		end

		repeat (DRAIN_CYC) @(negedge clk);
		if (mismatches == 0 && pending_res.size() == 0)
			$display("tb_rough_wall_eddy_viscosity: done, clean");
		else
			$display("tb_rough_wall_eddy_viscosity: done, errors");
		$finish;
	end

	// hard stop if the pipeline hangs
	initial begin
		#5_000_000;
		$display("tb_rough_wall_eddy_viscosity: done, errors");
		$finish;
	end

endmodule
